// ===== hdl/tilt_angle_gyro_bias_kalman_assert.svh =====
// assertion macros for the tilt kalman block
`ifndef TILT_ANGLE_GYRO_BIAS_KALMAN_ASSERT_SVH
`define TILT_ANGLE_GYRO_BIAS_KALMAN_ASSERT_SVH

// condition on this edge implies consequence on the next edge
`define TAGK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tagk assertion failed");

// condition implies consequence on the same edge
`define TAGK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tagk assertion failed");

`endif

// ===== hdl/tagk_pkg.sv =====
package tagk_pkg;

	typedef struct packed {
		logic signed [31:0] accel_angle;
		logic signed [31:0] gyro_rate;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] filtered_angle;
		logic signed [31:0] corrected_rate;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ANG,
		S_P00,
		S_P01,
		S_P10,
		S_P11,
		S_DIV0,
		S_DIV1,
		S_C11,
		S_C10,
		S_C01,
		S_C00,
		S_CA,
		S_CB,
		S_OUT
	} state_t;

	localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
	localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;
	localparam logic [1:0] REG_TIME_STEP     = 2'd3;

	localparam logic [30:0] ANGLE_NOISE_RST   = 31'd268435;
	localparam logic [30:0] BIAS_NOISE_RST    = 31'd805306;
	localparam logic [30:0] MEASURE_NOISE_RST = 31'd134217728;
	localparam logic [30:0] TIME_STEP_RST     = 31'd1342177;

	localparam logic signed [31:0] Q28_ONE = 32'sd268435456;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = S32_MAX;
		end else if (v < -40'sd2147483648) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/tagk_mac.sv =====
module tagk_mac (
	input  logic               clk,
	input  logic               mul_en,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	input  logic signed [31:0] addend,
	input  logic               sub,
	output logic signed [31:0] result
);

	logic signed [65:0] prod_s1;
	logic signed [65:0] biased;
	logic signed [37:0] rnd;
	logic signed [39:0] sum;

	// product register
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= op_a * op_b;
		end
	end

	// round half up to q28, then add or subtract and clamp
	assign biased = prod_s1 + 66'sd134217728;
	assign rnd    = $signed(biased[65:28]);
	assign sum    = sub ? (40'(addend) - 40'(rnd)) : (40'(addend) + 40'(rnd));
	assign result = tagk_pkg::sat32(sum);

endmodule

// ===== hdl/tagk_div.sv =====
module tagk_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic        [31:0] den,
	output logic               done,
	output logic signed [31:0] quot
);

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [59:0] nsh_q;
	logic [59:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [31:0] mag;
	logic [32:0] trial;
	logic        ge;

	assign mag   = num[31] ? (32'd0 - num) : num;
	assign trial = {rem_q, nsh_q[59]};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd59;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nsh_q <= {mag, 28'd0};
			quo_q <= '0;
			den_q <= den;
			neg_q <= num[31];
		end else if (run_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			nsh_q <= {nsh_q[58:0], 1'b0};
			quo_q <= {quo_q[58:0], ge};
		end
	end

	// sign and clamp
	always_comb begin
		if (!neg_q) begin
			quot = (quo_q > 60'd2147483647) ? tagk_pkg::S32_MAX : $signed(quo_q[31:0]);
		end else begin
			quot = (quo_q > 60'd2147483648) ? tagk_pkg::S32_MIN
				: $signed(32'd0 - quo_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== hdl/tilt_angle_gyro_bias_kalman.sv =====
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_data (accel_angle, gyro_rate)
// out      | out_valid / out_stall| out_data (filtered_angle, corrected_rate)
// cfg      | cfg_write            | cfg_index, cfg_data
// one item goes from acceptance to the next acceptance through eleven multiply-accumulate
// steps and two divisions (60 quotient bits, one a cycle), with a step each to accept it
// and to load the result; with a non-positive innovation variance both divisions are skipped.
// in_stall is high from acceptance until the result is loaded into the output register.
// a result waiting under out_stall does not block the next item until its load.
// reset restores default registers, zero estimates and identity covariance.
module tilt_angle_gyro_bias_kalman (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tagk_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tagk_pkg::out_item_t out_data,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [30:0]         cfg_data
);

	tagk_pkg::state_t state_q, state_d;
	logic phase_q, phase_d;

	logic [30:0] qa_q, qb_q, rm_q, dt_q;
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] k0_q, k1_q, err_q, accel_q, gyro_q;
	tagk_pkg::out_item_t out_q;
	logic out_valid_q;

	logic               mul_en;
	logic               wr_en;
	logic               div_start;
	logic signed [32:0] op_a, op_b;
	logic signed [31:0] addend;
	logic               sub;
	logic signed [31:0] mac_res;
	logic               div_done;
	logic signed [31:0] div_quot;
	logic signed [31:0] div_num;
	logic signed [32:0] innov_var;
	logic               var_pos;
	logic signed [31:0] d0, d1, err_now, rate_now;
	logic               out_free;

	// shared arithmetic
	tagk_mac u_mac (
		.clk    (clk),
		.mul_en (mul_en),
		.op_a   (op_a),
		.op_b   (op_b),
		.addend (addend),
		.sub    (sub),
		.result (mac_res)
	);

	tagk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (innov_var[31:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// derived terms
	assign d0        = tagk_pkg::sat32(40'($signed({9'd0, qa_q})) - 40'(p01_q) - 40'(p10_q));
	assign d1        = tagk_pkg::sat32(40'sd0 - 40'(p11_q));
	assign err_now   = tagk_pkg::sat32(40'(accel_q) - 40'(ang_q));
	assign rate_now  = tagk_pkg::sat32(40'(gyro_q) - 40'(bias_q));
	assign innov_var = $signed({2'd0, rm_q}) + 33'(p00_q);
	assign var_pos   = (innov_var > 33'sd0);
	assign div_num   = (state_q == tagk_pkg::S_DIV0) ? p00_q : p10_q;
	assign out_free  = !out_valid_q || !out_stall;

	// operand selection for each step
	always_comb begin
		op_a   = '0;
		op_b   = 33'($signed({2'd0, dt_q}));
		addend = '0;
		sub    = 1'b0;
		case (state_q)
			tagk_pkg::S_ANG: begin
				op_a   = 33'(gyro_q) - 33'(bias_q);
				addend = ang_q;
			end
			tagk_pkg::S_P00: begin
				op_a   = 33'(d0);
				addend = p00_q;
			end
			tagk_pkg::S_P01: begin
				op_a   = 33'(d1);
				addend = p01_q;
			end
			tagk_pkg::S_P10: begin
				op_a   = 33'(d1);
				addend = p10_q;
			end
			tagk_pkg::S_P11: begin
				op_a   = $signed({2'd0, qb_q});
				addend = p11_q;
			end
			tagk_pkg::S_C11: begin
				op_a   = 33'(k1_q);
				op_b   = 33'(p01_q);
				addend = p11_q;
				sub    = 1'b1;
			end
			tagk_pkg::S_C10: begin
				op_a   = 33'(k1_q);
				op_b   = 33'(p00_q);
				addend = p10_q;
				sub    = 1'b1;
			end
			tagk_pkg::S_C01: begin
				op_a   = 33'(k0_q);
				op_b   = 33'(p01_q);
				addend = p01_q;
				sub    = 1'b1;
			end
			tagk_pkg::S_C00: begin
				op_a   = 33'(k0_q);
				op_b   = 33'(p00_q);
				addend = p00_q;
				sub    = 1'b1;
			end
			tagk_pkg::S_CA: begin
				op_a   = 33'(k0_q);
				op_b   = 33'(err_q);
				addend = ang_q;
			end
			tagk_pkg::S_CB: begin
				op_a   = 33'(k1_q);
				op_b   = 33'(err_q);
				addend = bias_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tagk_pkg::S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		mul_en    = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			tagk_pkg::S_IDLE: begin
				phase_d = 1'b0;
				if (in_valid) begin
					state_d = tagk_pkg::S_ANG;
				end
			end
			tagk_pkg::S_ANG, tagk_pkg::S_P00, tagk_pkg::S_P01, tagk_pkg::S_P10,
			tagk_pkg::S_P11, tagk_pkg::S_C11, tagk_pkg::S_C10, tagk_pkg::S_C01,
			tagk_pkg::S_C00, tagk_pkg::S_CA, tagk_pkg::S_CB: begin
				mul_en  = !phase_q;
				wr_en   = phase_q;
				phase_d = !phase_q;
				if (phase_q) begin
					state_d = tagk_pkg::state_t'(state_q + 4'd1);
				end
			end
			tagk_pkg::S_DIV0: begin
				if (!phase_q) begin
					if (var_pos) begin
						div_start = 1'b1;
						phase_d   = 1'b1;
					end else begin
						state_d = tagk_pkg::S_C11;
					end
				end else if (div_done) begin
					state_d = tagk_pkg::S_DIV1;
					phase_d = 1'b0;
				end
			end
			tagk_pkg::S_DIV1: begin
				if (!phase_q) begin
					div_start = 1'b1;
					phase_d   = 1'b1;
				end else if (div_done) begin
					state_d = tagk_pkg::S_C11;
					phase_d = 1'b0;
				end
			end
			tagk_pkg::S_OUT: begin
				if (out_free) begin
					state_d = tagk_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tagk_pkg::S_IDLE;
				phase_d = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= tagk_pkg::ANGLE_NOISE_RST;
			qb_q <= tagk_pkg::BIAS_NOISE_RST;
			rm_q <= tagk_pkg::MEASURE_NOISE_RST;
			dt_q <= tagk_pkg::TIME_STEP_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tagk_pkg::REG_ANGLE_NOISE:   qa_q <= cfg_data;
				tagk_pkg::REG_BIAS_NOISE:    qb_q <= cfg_data;
				tagk_pkg::REG_MEASURE_NOISE: rm_q <= cfg_data;
				tagk_pkg::REG_TIME_STEP:     dt_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// filter state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= tagk_pkg::Q28_ONE;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= tagk_pkg::Q28_ONE;
		end else if (wr_en) begin
			case (state_q)
				tagk_pkg::S_ANG, tagk_pkg::S_CA:  ang_q  <= mac_res;
				tagk_pkg::S_CB:                   bias_q <= mac_res;
				tagk_pkg::S_P00, tagk_pkg::S_C00: p00_q  <= mac_res;
				tagk_pkg::S_P01, tagk_pkg::S_C01: p01_q  <= mac_res;
				tagk_pkg::S_P10, tagk_pkg::S_C10: p10_q  <= mac_res;
				tagk_pkg::S_P11, tagk_pkg::S_C11: p11_q  <= mac_res;
				default: begin
				end
			endcase
		end
	end

	// item capture, innovation, gains and result capture
	always_ff @(posedge clk) begin
		if (state_q == tagk_pkg::S_IDLE && in_valid) begin
			accel_q <= in_data.accel_angle;
			gyro_q  <= in_data.gyro_rate;
		end
		if (state_q == tagk_pkg::S_DIV0 && !phase_q) begin
			err_q <= err_now;
			if (!var_pos) begin
				k0_q <= '0;
				k1_q <= '0;
			end
		end
		if (div_done && phase_q) begin
			if (state_q == tagk_pkg::S_DIV0) begin
				k0_q <= div_quot;
			end else begin
				k1_q <= div_quot;
			end
		end
		if (state_q == tagk_pkg::S_OUT && out_free) begin
			out_q.filtered_angle <= ang_q;
			out_q.corrected_rate <= rate_now;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tagk_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != tagk_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/tagk_checker.sv =====
`include "tilt_angle_gyro_bias_kalman_assert.svh"

module tagk_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input tagk_pkg::out_item_t out_data
);

	// a waiting result stays put
	`TAGK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`TAGK_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
	// an accepted item keeps the block busy for its arithmetic
	`TAGK_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`TAGK_ASSERT_NEXT(a_busy_two_after, in_valid && !in_stall, ##1 in_stall)

endmodule

bind tilt_angle_gyro_bias_kalman tagk_checker u_tagk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	tagk_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall = 1'b0;
	tagk_pkg::out_item_t out_data;
	logic                cfg_write;
	logic [1:0]          cfg_index;
	logic [30:0]         cfg_data;

	tilt_angle_gyro_bias_kalman u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// filter settings and state as the predictor tracks them
	longint q_angle, q_bias, r_meas, dt;
	longint ang_est, bias_est;
	longint cov [4];

	tagk_pkg::out_item_t expected_q [$];
	int errors = 0;
	int n_results = 0;
	int n_items = 0;
	int send_idle = 0;
	int recv_idle = 0;

	localparam longint ONE_Q28 = 64'sd268435456;
	localparam longint HALF_Q28 = 64'sd134217728;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;

	function automatic longint clamp(input longint v);
		if (v > MAXV) return MAXV;
		if (v < MINV) return MINV;
		return v;
	endfunction

	// scale by 2^-28, round half up (arithmetic shift floors)
	function automatic longint rnd28(input longint x);
		return (x + HALF_Q28) >>> 28;
	endfunction

	function automatic longint mulr(input longint a, input longint b);
		return rnd28(a * b);
	endfunction

	task automatic reset_filter();
		q_angle = 64'(tagk_pkg::ANGLE_NOISE_RST);
		q_bias = 64'(tagk_pkg::BIAS_NOISE_RST);
		r_meas = 64'(tagk_pkg::MEASURE_NOISE_RST);
		dt = 64'(tagk_pkg::TIME_STEP_RST);
		ang_est = 0;
		bias_est = 0;
		cov[0] = ONE_Q28; cov[1] = 0; cov[2] = 0; cov[3] = ONE_Q28;
	endtask

	// one kalman step: predict, gain, correct
	function automatic tagk_pkg::out_item_t kalman_step(input tagk_pkg::in_item_t s);
		longint acc, gyr, p00, p01, p10, p11, d, innov, e, k0, k1;
		tagk_pkg::out_item_t r;
		acc = 64'(s.accel_angle);
		gyr = 64'(s.gyro_rate);
		k0 = 0; k1 = 0;
		ang_est = clamp(ang_est + rnd28((gyr - bias_est) * dt));
		p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
		d = clamp(q_angle - p01 - p10);
		p00 = clamp(p00 + mulr(d, dt));
		d = clamp(-p11);
		p01 = clamp(p01 + mulr(d, dt));
		p10 = clamp(p10 + mulr(d, dt));
		p11 = clamp(p11 + mulr(q_bias, dt));
		innov = clamp(acc - ang_est);
		e = r_meas + p00;
		// non-positive innovation variance leaves gains at zero
		if (e > 0) begin
			k0 = clamp((p00 * ONE_Q28) / e);
			k1 = clamp((p10 * ONE_Q28) / e);
		end
		cov[0] = clamp(p00 - mulr(k0, p00));
		cov[1] = clamp(p01 - mulr(k0, p01));
		cov[2] = clamp(p10 - mulr(k1, p00));
		cov[3] = clamp(p11 - mulr(k1, p01));
		ang_est = clamp(ang_est + mulr(k0, innov));
		bias_est = clamp(bias_est + mulr(k1, innov));
		r.filtered_angle = ang_est[31:0];
		r.corrected_rate = 32'(clamp(gyr - bias_est));
		return r;
	endfunction

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		tagk_pkg::out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_q.size() == 0) begin
				$error("unexpected result item %h", out_data);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (out_data.filtered_angle !== exp_r.filtered_angle) begin
					$error("filtered_angle expected %0d actual %0d",
						exp_r.filtered_angle, out_data.filtered_angle);
					errors++;
				end
				if (out_data.corrected_rate !== exp_r.corrected_rate) begin
					$error("corrected_rate expected %0d actual %0d",
						exp_r.corrected_rate, out_data.corrected_rate);
					errors++;
				end
			end
		end
	end

	// receiver stall, changed at the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// drive one item and wait for acceptance; predict on acceptance
	task automatic send_item(input tagk_pkg::in_item_t s);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(kalman_step(s));
		n_items++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			tagk_pkg::REG_ANGLE_NOISE:   q_angle = 64'(val);
			tagk_pkg::REG_BIAS_NOISE:    q_bias = 64'(val);
			tagk_pkg::REG_MEASURE_NOISE: r_meas = 64'(val);
			default:                     dt = 64'(val);
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	// directed items: the first row after reset, extremes of both fields and other bit patterns
	typedef struct {
		tagk_pkg::in_item_t  s;
		bit                  has_exp;
		tagk_pkg::out_item_t r;
	} stim_row_t;

	stim_row_t dir_rows [] = '{
		// zero input after reset stays at zero
		'{'{32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0}},
		'{'{32'sh00010000, 32'sh00010000}, 1'b0, '{32'sd0, 32'sd0}},
		'{'{32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1'b0, '{32'sd0, 32'sd0}},
		'{'{32'sh80000000, 32'sh80000000}, 1'b0, '{32'sd0, 32'sd0}},
		'{'{32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '{32'sd0, 32'sd0}},
		'{'{32'sh80000000, 32'sh7FFFFFFF}, 1'b0, '{32'sd0, 32'sd0}},
		'{'{32'shFFFFFFFF, 32'sh55555555}, 1'b0, '{32'sd0, 32'sd0}},
		'{'{32'shAAAAAAAA, 32'sd1}, 1'b0, '{32'sd0, 32'sd0}}
	};

	// setting sets: extremes, zero step, unit step, max measure noise, defaults, mid values
	logic [30:0] cfg_sets [6][4] = '{
		'{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF},
		'{31'd0, 31'd0, 31'd1, 31'd0},
		'{31'd268435, 31'd805306, 31'd1, 31'd268435456},
		'{31'd1000, 31'd2000, 31'h7FFFFFFF, 31'd1342177},
		'{31'd268435, 31'd805306, 31'd134217728, 31'd1342177},
		'{31'd50000, 31'd100000, 31'd26843545, 31'd2684354}
	};

	initial begin
		tagk_pkg::in_item_t s;
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = tagk_pkg::REG_ANGLE_NOISE;
		cfg_data = '0;
		reset_filter();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp) begin
				send_item(dir_rows[i].s);
				void'(expected_q.pop_back());
				expected_q.push_back(dir_rows[i].r);
			end else begin
				send_item(dir_rows[i].s);
			end
		end
		drain();

		// random phases through the setting sets and idle profiles
		for (phase = 0; phase < 6; phase++) begin
			for (int k = 0; k < 4; k++) write_reg(k[1:0], cfg_sets[phase][k]);
			send_idle = (phase < 2) ? 22 : (phase < 4) ? 87 : 0;
			recv_idle = (phase < 2) ? 87 : (phase < 4) ? 22 : 0;
			for (int n = 0; n < 165; n++) begin
				if ($urandom_range(3) == 0) begin
					s.accel_angle = rand_field();
					s.gyro_rate = rand_field();
				end else begin
					// plausible tilt angles and gyro rates of small magnitude
					s.accel_angle = $signed($urandom_range(400000)) - 200000;
					s.gyro_rate = $signed($urandom_range(40000)) - 20000;
				end
				send_item(s);
			end
			recv_idle = 0;
			drain();
		end

		$display("ran %0d items with %0d results over 6 filter settings",
			n_items, n_results);
		if (errors == 0) begin
			$display("tilt_angle_gyro_bias_kalman test passed");
		end else begin
			$display("tilt_angle_gyro_bias_kalman test failed");
		end
		$finish;
	end

	// timeout
	initial begin
		#20000000;
		$display("tilt_angle_gyro_bias_kalman test failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tagk_pkg.sv
hdl/tagk_mac.sv
hdl/tagk_div.sv
hdl/tilt_angle_gyro_bias_kalman.sv
hdl/tagk_checker.sv
verif/tb_top.sv
